// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("stream_kth_largest_tracker: assertion failed");

`define ASSERT_NEVER(lbl, ck, rn, expr) \
    `ASSERT_CLK(lbl, ck, rn, !(expr))

`endif

// ===== rtl/core/skt_pkg.sv =====
package skt_pkg;

    localparam int DATA_W       = 32;
    localparam int RANK_W       = 7;
    localparam int MAX_RANK_DEF = 64;
    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DOWN,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== rtl/core/stream_kth_largest_tracker.sv =====
// Tracks the K largest signed 32-bit values of a stream and reports the
// smallest of them after every item, with K taken from the k_rank register.
// Channels: input items on in_valid/in_ready/sample_value, results on
// out_valid/out_ready/kth_value/filled, register writes on cfg_valid/cfg_ready
// with k_rank as data (0 acts as 1, values above MAX_RANK act as MAX_RANK).
// Values are kept as a binary min-heap in a one-port-write, two-port-read
// memory; every heap level costs one read-compare-write.
// An item that is dropped or written straight to the root goes from
// S_IDLE to S_DONE; any other item walks the heap in S_UP or S_DOWN,
// and S_PUT writes it when it reaches the root or a leaf.
// One item is in the heap unit at a time: a new item is taken only once
// the previous one has gone from S_DONE back to S_IDLE.
// A stalled result sits in the output register; the next item is still
// accepted and processed, and waits only for that register to empty.
// Reset empties the store and sets K to 1; no clearing pass is needed.
module stream_kth_largest_tracker
    import skt_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [RANK_W-1:0]        k_rank,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] kth_value,
    output logic                     filled
);

    localparam int ADDR_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CNT_W  = $clog2(MAX_RANK + 1);

    mem_ctl_t                 mem_ctl;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr_a;
    logic [ADDR_W-1:0]        mem_raddr_b;
    logic signed [DATA_W-1:0] mem_rdata_a;
    logic signed [DATA_W-1:0] mem_rdata_b;

    assign cfg_ready = 1'b1;

    skt_heap_ctrl #(
        .MAX_RANK (MAX_RANK),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .k_rank       (k_rank),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kth_value    (kth_value),
        .filled       (filled),
        .mem_ctl      (mem_ctl),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr_a  (mem_raddr_a),
        .mem_raddr_b  (mem_raddr_b),
        .mem_rdata_a  (mem_rdata_a),
        .mem_rdata_b  (mem_rdata_b)
    );

    skt_heap_ram #(
        .DEPTH  (MAX_RANK),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (mem_ctl),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

endmodule

// ===== rtl/core/skt_heap_ram.sv =====
module skt_heap_ram
    import skt_pkg::*;
#(
    parameter int DEPTH  = MAX_RANK_DEF,
    parameter int ADDR_W = 6
)
(
    input  logic                     clk,
    input  mem_ctl_t                 ctl,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr_a,
    input  logic [ADDR_W-1:0]        raddr_b,
    output logic signed [DATA_W-1:0] rdata_a,
    output logic signed [DATA_W-1:0] rdata_b
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/core/skt_heap_ctrl.sv =====
module skt_heap_ctrl
    import skt_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF,
    parameter int ADDR_W   = 6,
    parameter int CNT_W    = 7
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [RANK_W-1:0]        k_rank,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] kth_value,
    output logic                     filled,
    output mem_ctl_t                 mem_ctl,
    output logic [ADDR_W-1:0]        mem_waddr,
    output logic signed [DATA_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0]        mem_raddr_a,
    output logic [ADDR_W-1:0]        mem_raddr_b,
    input  logic signed [DATA_W-1:0] mem_rdata_a,
    input  logic signed [DATA_W-1:0] mem_rdata_b
);

    localparam int IDX_W = ADDR_W + 2;

    state_t                   state_reg, state_next;
    logic [RANK_W-1:0]        k_rank_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ADDR_W-1:0]        hole_reg, hole_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] root_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] kth_reg, kth_next;
    logic                     filled_reg, filled_next;

    logic [CNT_W-1:0]         k_eff;
    logic [ADDR_W-1:0]        cnt_addr;
    logic [IDX_W-1:0]         cnt_ext;
    logic                     do_insert, do_replace;
    logic [ADDR_W-1:0]        par_idx;
    logic [IDX_W-1:0]         c1_idx, c2_idx;
    logic                     pick_b;
    logic signed [DATA_W-1:0] small_val;
    logic [ADDR_W-1:0]        small_idx;
    logic [IDX_W-1:0]         g1_idx;
    logic                     up_move, down_move, out_free;

    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] h);
        parent_of = (h - ADDR_W'(1)) >> 1;
    endfunction

    function automatic logic [IDX_W-1:0] child_of(input logic [ADDR_W-1:0] h);
        child_of = {1'b0, h, 1'b1};
    endfunction

    // rank clamp
    always_comb
    begin
        if (k_rank_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (32'(k_rank_reg) > 32'(MAX_RANK))
        begin
            k_eff = CNT_W'(MAX_RANK);
        end
        else
        begin
            k_eff = CNT_W'(k_rank_reg);
        end
    end

    // decisions shared by next-state and output logic
    always_comb
    begin
        cnt_addr   = ADDR_W'(cnt_reg);
        cnt_ext    = IDX_W'(cnt_reg);
        do_insert  = (cnt_reg < k_eff) && (cnt_reg != CNT_W'(MAX_RANK));
        do_replace = (cnt_reg != '0) && (sample_value > root_reg);
        par_idx    = parent_of(hole_reg);
        c1_idx     = child_of(hole_reg);
        c2_idx     = c1_idx + IDX_W'(1);
        pick_b     = (c2_idx < cnt_ext) && (mem_rdata_b < mem_rdata_a);
        small_val  = pick_b ? mem_rdata_b : mem_rdata_a;
        small_idx  = pick_b ? ADDR_W'(c2_idx) : ADDR_W'(c1_idx);
        g1_idx     = child_of(small_idx);
        up_move    = mem_rdata_a > key_reg;
        down_move  = small_val < key_reg;
        out_free   = !out_valid_reg || out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (do_insert && (cnt_reg != '0))
                    begin
                        state_next = S_UP;
                    end
                    else if (!do_insert && do_replace && (cnt_reg != CNT_W'(1)))
                    begin
                        state_next = S_DOWN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_UP:
            begin
                if (!up_move)
                begin
                    state_next = S_DONE;
                end
                else if (par_idx == '0)
                begin
                    state_next = S_PUT;
                end
            end
            S_DOWN:
            begin
                if (!down_move)
                begin
                    state_next = S_DONE;
                end
                else if (g1_idx >= cnt_ext)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        mem_ctl        = '0;
        mem_waddr      = hole_reg;
        mem_wdata      = key_reg;
        mem_raddr_a    = par_idx;
        mem_raddr_b    = par_idx;
        hole_next      = hole_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kth_next       = kth_reg;
        filled_next    = filled_reg;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next = sample_value;
                    if (do_insert)
                    begin
                        cnt_next  = cnt_reg + CNT_W'(1);
                        hole_next = cnt_addr;
                        if (cnt_reg == '0)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_waddr     = '0;
                            mem_wdata     = sample_value;
                        end
                        else
                        begin
                            mem_ctl.rd_en = 1'b1;
                            mem_raddr_a   = parent_of(cnt_addr);
                        end
                    end
                    else if (do_replace)
                    begin
                        hole_next = '0;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_waddr     = '0;
                            mem_wdata     = sample_value;
                        end
                        else
                        begin
                            mem_ctl.rd_en = 1'b1;
                            mem_raddr_a   = ADDR_W'(child_of('0));
                            mem_raddr_b   = ADDR_W'(child_of('0) + IDX_W'(1));
                        end
                    end
                end
            end
            S_UP:
            begin
                mem_ctl.wr_en = 1'b1;
                if (up_move)
                begin
                    mem_wdata = mem_rdata_a;
                    hole_next = par_idx;
                    if (par_idx != '0)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        mem_raddr_a   = parent_of(par_idx);
                    end
                end
            end
            S_DOWN:
            begin
                mem_ctl.wr_en = 1'b1;
                if (down_move)
                begin
                    mem_wdata = small_val;
                    hole_next = small_idx;
                    if (g1_idx < cnt_ext)
                    begin
                        mem_ctl.rd_en = 1'b1;
                        mem_raddr_a   = ADDR_W'(g1_idx);
                        mem_raddr_b   = ADDR_W'(g1_idx + IDX_W'(1));
                    end
                end
            end
            S_PUT:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kth_next       = root_reg;
                    filled_next    = cnt_reg >= k_eff;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_rank_reg    <= RANK_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                k_rank_reg <= k_rank;
            end
        end
    end

    // datapath registers, and the heap root shadow that follows every write to entry zero
    always_ff @(posedge clk)
    begin
        hole_reg   <= hole_next;
        key_reg    <= key_next;
        kth_reg    <= kth_next;
        filled_reg <= filled_next;
        if (mem_ctl.wr_en && (mem_waddr == '0))
        begin
            root_reg <= mem_wdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign kth_value = kth_reg;
    assign filled    = filled_reg;

endmodule

// ===== rtl/core/skt_checker.sv =====
`include "assert_macros.svh"

module skt_checker
    import skt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_valid,
    input logic                     cfg_ready,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] kth_value,
    input logic                     filled
);

    logic [1:0] pend_reg, pend_next;
    logic       seen_filled_reg, seen_filled_next;
    logic       in_acc, out_acc, cfg_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign cfg_acc = cfg_valid && cfg_ready;

    // items taken but not yet delivered, and whether a filled result was seen since the last rank write
    always_comb
    begin
        pend_next = pend_reg + 2'(in_acc) - 2'(out_acc);
        if (cfg_acc)
        begin
            seen_filled_next = 1'b0;
        end
        else
        begin
            seen_filled_next = seen_filled_reg || (out_acc && filled);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg        <= '0;
            seen_filled_reg <= 1'b0;
        end
        else
        begin
            pend_reg        <= pend_next;
            seen_filled_reg <= seen_filled_next;
        end
    end

    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(kth_value) && $stable(filled))
    `ASSERT_NEVER(a_no_extra_item, clk, rst_n, out_valid && (pend_reg == 2'd0))
    `ASSERT_CLK(a_one_in_flight, clk, rst_n, in_acc |-> pend_reg <= 2'd1)
    `ASSERT_CLK(a_filled_stays, clk, rst_n, out_valid && seen_filled_reg && !cfg_acc |-> filled)

endmodule

bind stream_kth_largest_tracker skt_checker u_skt_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import skt_pkg::*;

    localparam int KEEP_MAX = MAX_RANK_DEF;
    localparam int SETTLE = 3 + $clog2(KEEP_MAX) + 8;
    localparam int PHASE_ITEMS = 136;
    localparam int NUM_PHASES = 9;
    localparam int NUM_ROWS = 24;
    localparam int HOLD_CYCLES = 300;
    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum {ROW_SAMPLE, ROW_RANK} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        value;
        bit        typed;
        int        kth;
        bit        filled;
    } plan_row_t;

    typedef struct {
        logic signed [DATA_W-1:0] kth;
        logic                     filled;
    } kth_report_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [RANK_W-1:0]        k_rank = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] sample_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] kth_value;
    logic                     filled;

    // sorted copy of the values the block should be holding
    logic signed [DATA_W-1:0] held_sorted [KEEP_MAX];
    int                       held_n = 0;
    logic [RANK_W-1:0]        rank_now = RANK_RESET;

    kth_report_t pending_reports [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_ask = 0;
    int hold_left = 0;
    int fail_count = 0;
    int samples_sent = 0;
    int reports_seen = 0;
    int rank_writes = 0;

    int idle_modes [4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{18, 18}};
    int phase_ranks [NUM_PHASES] = '{2, 5, 0, 16, 64, 100, 3, 127, 1};

    plan_row_t plan [NUM_ROWS] = '{
        '{ROW_SAMPLE, 100, 1, 100, 1},
        '{ROW_SAMPLE, MOST_NEG, 1, 100, 1},
        '{ROW_SAMPLE, MOST_POS, 1, MOST_POS, 1},
        '{ROW_SAMPLE, MOST_POS, 1, MOST_POS, 1},
        '{ROW_RANK, 3, 0, 0, 0},
        '{ROW_SAMPLE, -5, 1, -5, 0},
        '{ROW_SAMPLE, 0, 0, 0, 0},
        '{ROW_SAMPLE, MOST_NEG, 0, 0, 0},
        '{ROW_SAMPLE, 7, 0, 0, 0},
        '{ROW_SAMPLE, 0, 0, 0, 0},
        '{ROW_RANK, 0, 0, 0, 0},
        '{ROW_SAMPLE, 1, 0, 0, 0},
        '{ROW_SAMPLE, -1, 0, 0, 0},
        '{ROW_RANK, 127, 0, 0, 0},
        '{ROW_SAMPLE, MOST_NEG, 1, MOST_NEG, 0},
        '{ROW_SAMPLE, -1, 0, 0, 0},
        '{ROW_SAMPLE, 32'sh5555_5555, 0, 0, 0},
        '{ROW_SAMPLE, 32'shaaaa_aaaa, 0, 0, 0},
        '{ROW_RANK, 64, 0, 0, 0},
        '{ROW_SAMPLE, MOST_POS, 0, 0, 0},
        '{ROW_SAMPLE, 0, 0, 0, 0},
        '{ROW_RANK, 1, 0, 0, 0},
        '{ROW_SAMPLE, 2, 0, 0, 0},
        '{ROW_SAMPLE, MOST_NEG, 0, 0, 0}
    };

    stream_kth_largest_tracker #(
        .MAX_RANK(KEEP_MAX)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .k_rank(k_rank),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_value(sample_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kth_value(kth_value),
        .filled(filled)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int rank_limit();
        int k;
        k = rank_now;
        if (k < 1)
            k = 1;
        if (k > KEEP_MAX)
            k = KEEP_MAX;
        return k;
    endfunction

    function automatic kth_report_t track_sample(input logic signed [DATA_W-1:0] v);
        kth_report_t r;
        int k;
        int i;
        k = rank_limit();
        if (held_n < k && held_n < KEEP_MAX)
        begin
            i = held_n;
            while (i > 0 && held_sorted[i-1] > v)
            begin
                held_sorted[i] = held_sorted[i-1];
                i--;
            end
            held_sorted[i] = v;
            held_n++;
        end
        else if (held_n > 0 && v > held_sorted[0])
        begin
            // smallest drops out, new value slides up to its place
            i = 0;
            while (i + 1 < held_n && held_sorted[i+1] < v)
            begin
                held_sorted[i] = held_sorted[i+1];
                i++;
            end
            held_sorted[i] = v;
        end
        r.kth = held_sorted[0];
        r.filled = (held_n >= k);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2, 3, 4: return DATA_W'(int'($urandom_range(40)) - 20);
            5, 6:
            begin
                if (held_n > 0)
                    return held_sorted[0] + DATA_W'(int'($urandom_range(6)) - 3);
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic put_sample(input logic signed [DATA_W-1:0] v, input bit typed,
                              input kth_report_t given);
        kth_report_t r;
        in_valid <= 1'b1;
        sample_value <= v;
        do @(posedge clk); while (!in_ready);
        r = track_sample(v);
        pending_reports.push_back(typed ? given : r);
        samples_sent++;
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] v);
        drain_reports();
        cfg_valid <= 1'b1;
        k_rank <= v;
        do @(posedge clk); while (!cfg_ready);
        rank_now = v;
        rank_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_report();
        kth_report_t want;
        reports_seen++;
        if (pending_reports.size() == 0)
        begin
            $error("unexpected item: kth_value %0d filled %0b", kth_value, filled);
            fail_count++;
        end
        else
        begin
            want = pending_reports.pop_front();
            if (kth_value !== want.kth)
            begin
                $error("kth_value mismatch: expected %0d, actual %0d", want.kth, kth_value);
                fail_count++;
            end
            if (filled !== want.filled)
            begin
                $error("filled mismatch: expected %0b, actual %0b", want.filled, filled);
                fail_count++;
            end
        end
    endtask

    // receiver side, with its own count of the long hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_report();
            if (hold_ask > 0)
            begin
                hold_left = hold_ask;
                hold_ask = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("stream_kth_largest_tracker regression: fail");
        $finish;
    end

    initial
    begin
        kth_report_t given;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_RANK)
                write_rank(RANK_W'(plan[r].value));
            else
            begin
                given.kth = plan[r].kth;
                given.filled = plan[r].filled;
                put_sample(plan[r].value, plan[r].typed, given);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_rank(RANK_W'(phase_ranks[p]));
            send_idle_pct = idle_modes[p % 4][0];
            recv_stall_pct = idle_modes[p % 4][1];
            // long receiver hold while items keep coming, fills the block
            if (p == 0)
                hold_ask = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 5 && n == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (pending_reports.size() != 0);
                end
                put_sample(pick_sample(), 1'b0, given);
                sender_gap();
            end
        end

        drain_reports();
        $display("covered %0d samples and %0d items out, %0d rank writes from 0 to 127,",
                 samples_sent, reports_seen, rank_writes);
        $display("with no idling, sender idle, receiver stalls, both, and one long hold");
        if (fail_count == 0)
            $display("stream_kth_largest_tracker regression: pass");
        else
            $display("stream_kth_largest_tracker regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/skt_pkg.sv
rtl/core/skt_heap_ram.sv
rtl/core/skt_heap_ctrl.sv
rtl/core/stream_kth_largest_tracker.sv
rtl/core/skt_checker.sv
test/tb.sv
